/* rtl/sprx_pkg.sv */
package sprx_pkg;

    // receive fifo geometry
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // fifo control from the port logic
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

/* rtl/sprx_rx_fifo.sv */
module sprx_rx_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sprx_pkg::fifo_ctl_t       ctl,
    input  logic [7:0]                push_data,
    output logic [7:0]                head_data,
    output logic [sprx_pkg::FILL_W-1:0] fill
);

    logic [7:0]                   store [sprx_pkg::FIFO_DEPTH];
    logic [7:0]                   head_data_reg;
    logic [sprx_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [sprx_pkg::PTR_W-1:0]   tail_reg, tail_next;
    logic [sprx_pkg::FILL_W-1:0]  fill_reg, fill_next;

    localparam logic [sprx_pkg::PTR_W-1:0] LAST_PTR =
        sprx_pkg::PTR_W'(sprx_pkg::FIFO_DEPTH - 1);

    // storage has no reset, only valid entries are ever read
    // head word kept in a register: loaded on a push into an empty fifo,
    // refreshed from the next entry on a pop that leaves words behind
    always_ff @(posedge aclk) begin
        if (ctl.push && !ctl.clear) begin
            store[tail_reg] <= push_data;
            if (fill_reg == '0) begin
                head_data_reg <= push_data;
            end
        end else if (ctl.pop && !ctl.clear && (fill_reg > sprx_pkg::FILL_W'(1))) begin
            head_data_reg <= store[head_next];
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctl.clear) begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end else if (ctl.push) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end else if (ctl.pop) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign head_data = head_data_reg;
    assign fill      = fill_reg;

endmodule

/* rtl/serial_port_with_rx_fifo.sv */
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_link_enabled
// s_        in         s_valid/s_ready      s_cmd s_wdata s_peer_byte s_peer_dsr s_peer_cts
// m_        out        m_valid/m_ready      m_rdata m_tx_* m_lines_valid m_dtr_out m_rts_out
//                                           m_irq_raise
//
// one word in per clock while s_ready is high; its result is registered into the output queue
// a two-entry output queue (output register plus skid) keeps s_ready high
// while one result waits; s_ready drops only with both entries full
// aresetn is synchronous, active low, and clears all port state
// the config write is always taken (cfg_ready tied high)
module serial_port_with_rx_fifo (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_link_enabled,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [15:0] s_wdata,
    input  logic [7:0]  s_peer_byte,
    input  logic        s_peer_dsr,
    input  logic        s_peer_cts,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_rdata,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic [25:0] m_tx_cycles,
    output logic        m_lines_valid,
    output logic        m_dtr_out,
    output logic        m_rts_out,
    output logic        m_irq_raise
);

    // bus and peer commands
    localparam logic [3:0] CMD_WR_DATA = 4'd0;
    localparam logic [3:0] CMD_WR_MODE = 4'd1;
    localparam logic [3:0] CMD_WR_CTRL = 4'd2;
    localparam logic [3:0] CMD_WR_BAUD = 4'd3;
    localparam logic [3:0] CMD_RD_DATA = 4'd4;
    localparam logic [3:0] CMD_RD_STAT = 4'd5;
    localparam logic [3:0] CMD_RD_MODE = 4'd6;
    localparam logic [3:0] CMD_RD_CTRL = 4'd7;
    localparam logic [3:0] CMD_RD_BAUD = 4'd8;
    localparam logic [3:0] CMD_RX_BYTE = 4'd9;
    localparam logic [3:0] CMD_PEER    = 4'd10;
    localparam logic [3:0] CMD_TICK    = 4'd11;

    // control word bits
    localparam int CT_TX_EN   = 0;
    localparam int CT_DTR     = 1;
    localparam int CT_ACK     = 4;
    localparam int CT_RTS     = 5;
    localparam int CT_RESET   = 6;
    localparam int CT_TX_IRQ  = 10;
    localparam int CT_RX_IRQ  = 11;
    localparam int CT_DSR_IRQ = 12;

    localparam logic [2:0]  ERR_OVERRUN   = 3'b010;
    localparam logic [15:0] STAT_UNLINKED = 16'h00a0;
    localparam logic [15:0] RD_EMPTY      = 16'h00ff;

    typedef struct packed {
        logic [15:0] rdata;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [25:0] tx_cycles;
        logic        lines_valid;
        logic        dtr_out;
        logic        rts_out;
        logic        irq_raise;
    } result_t;

    // wire time of one byte: bit time times bits per byte
    function automatic logic [25:0] wire_time(input logic [15:0] mode,
                                              input logic [15:0] baud);
        logic [21:0] bit_time;
        logic [3:0]  n_bits;
        begin
            unique case (mode[1:0])
                2'd2:    bit_time = {2'b00, baud, 4'b0000};
                2'd3:    bit_time = {baud, 6'b000000};
                default: bit_time = {6'b000000, baud};
            endcase
            if (bit_time < 22'd8) begin
                bit_time = 22'd8;
            end
            n_bits = 4'd6 + {2'b00, mode[3:2]} + {3'b000, mode[4]}
                     + ((mode[7:6] == 2'b11) ? 4'd2 : 4'd1);
            wire_time = {4'b0000, bit_time} * {22'd0, n_bits};
        end
    endfunction

    // architectural state
    logic        link_reg;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic [15:0] baud_reg, baud_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        hold_full_reg, hold_full_next;
    logic        sending_reg, sending_next;
    logic [25:0] remain_reg, remain_next;
    logic [25:0] remain_dec;
    logic [2:0]  err_reg, err_next;
    logic        irq_reg, irq_next;
    logic        dsr_reg, dsr_next;
    logic        cts_reg, cts_next;

    // output queue
    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    result_t     res;
    logic        accept;
    logic        take;
    logic        try_tx;
    logic [7:0]  fill_inc;
    logic [7:0]  rx_thresh;

    sprx_pkg::fifo_ctl_t        fifo_ctl;
    logic [7:0]                 fifo_head;
    logic [sprx_pkg::FILL_W-1:0] fifo_fill;

    sprx_rx_fifo u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (fifo_ctl),
        .push_data (s_peer_byte),
        .head_data (fifo_head),
        .fill      (fifo_fill)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign take      = out_valid_reg && m_ready;

    assign fill_inc   = 8'(fifo_fill) + 8'd1;
    assign rx_thresh  = 8'd1 << ctrl_reg[9:8];
    assign remain_dec = (remain_reg == '0) ? '0 : remain_reg - 26'd1;

    // one word: state update and result in a single pass
    always_comb begin
        mode_next      = mode_reg;
        ctrl_next      = ctrl_reg;
        baud_next      = baud_reg;
        hold_byte_next = hold_byte_reg;
        hold_full_next = hold_full_reg;
        sending_next   = sending_reg;
        remain_next    = remain_reg;
        err_next       = err_reg;
        irq_next       = irq_reg;
        dsr_next       = dsr_reg;
        cts_next       = cts_reg;
        fifo_ctl       = '0;
        res            = '0;
        try_tx         = 1'b0;

        if (accept) begin
            unique case (s_cmd)
                CMD_WR_DATA: begin
                    hold_byte_next = s_wdata[7:0];
                    hold_full_next = 1'b1;
                    try_tx         = 1'b1;
                end
                CMD_WR_MODE: mode_next = s_wdata;
                CMD_WR_CTRL: begin
                    if (s_wdata[CT_RESET]) begin
                        // momentary port reset, link setting survives
                        mode_next      = '0;
                        ctrl_next      = '0;
                        baud_next      = '0;
                        hold_byte_next = '0;
                        hold_full_next = 1'b0;
                        sending_next   = 1'b0;
                        remain_next    = '0;
                        err_next       = '0;
                        irq_next       = 1'b0;
                        dsr_next       = 1'b0;
                        cts_next       = 1'b0;
                        fifo_ctl.clear = 1'b1;
                        res.lines_valid = link_reg;
                    end else begin
                        if (s_wdata[CT_ACK]) begin
                            err_next = '0;
                            irq_next = 1'b0;
                        end
                        ctrl_next          = s_wdata;
                        ctrl_next[CT_ACK]  = 1'b0;
                        if (link_reg && ((s_wdata[CT_DTR] != ctrl_reg[CT_DTR]) ||
                                         (s_wdata[CT_RTS] != ctrl_reg[CT_RTS]))) begin
                            res.lines_valid = 1'b1;
                            res.dtr_out     = s_wdata[CT_DTR];
                            res.rts_out     = s_wdata[CT_RTS];
                        end
                        try_tx = 1'b1;
                    end
                end
                CMD_WR_BAUD: baud_next = s_wdata;
                CMD_RD_DATA: begin
                    if (fifo_fill == '0) begin
                        res.rdata = RD_EMPTY;
                    end else begin
                        res.rdata    = {8'h00, fifo_head};
                        fifo_ctl.pop = 1'b1;
                    end
                end
                CMD_RD_STAT: begin
                    if (link_reg) begin
                        res.rdata = {6'b000000, irq_reg, cts_reg, dsr_reg, 1'b0,
                                     err_reg, !hold_full_reg && !sending_reg,
                                     fifo_fill != '0, !hold_full_reg};
                    end else begin
                        res.rdata = STAT_UNLINKED;
                    end
                end
                CMD_RD_MODE: res.rdata = mode_reg;
                CMD_RD_CTRL: res.rdata = ctrl_reg;
                CMD_RD_BAUD: res.rdata = baud_reg;
                CMD_RX_BYTE: begin
                    if (link_reg) begin
                        if (fifo_fill == sprx_pkg::FILL_W'(sprx_pkg::FIFO_DEPTH)) begin
                            err_next = err_reg | ERR_OVERRUN;
                        end else begin
                            fifo_ctl.push = 1'b1;
                            // threshold beyond depth never fires
                            if (ctrl_reg[CT_RX_IRQ] && (fill_inc >= rx_thresh) &&
                                !irq_reg) begin
                                irq_next      = 1'b1;
                                res.irq_raise = 1'b1;
                            end
                        end
                    end
                end
                CMD_PEER: begin
                    if (link_reg) begin
                        dsr_next = s_peer_dsr;
                        cts_next = s_peer_cts;
                        if (s_peer_dsr && !dsr_reg && ctrl_reg[CT_DSR_IRQ] &&
                            !irq_reg) begin
                            irq_next      = 1'b1;
                            res.irq_raise = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (link_reg && sending_reg) begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            sending_next = 1'b0;
                            if (ctrl_reg[CT_TX_IRQ] && !irq_reg) begin
                                irq_next      = 1'b1;
                                res.irq_raise = 1'b1;
                            end
                            try_tx = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // start the held byte when enabled and the wire is idle; with no link the byte is dropped
        if (try_tx && !sending_next && hold_full_next && ctrl_next[CT_TX_EN]) begin
            hold_full_next = 1'b0;
            if (link_reg) begin
                sending_next  = 1'b1;
                remain_next   = wire_time(mode_next, baud_next);
                res.tx_valid  = 1'b1;
                res.tx_byte   = hold_byte_next;
                res.tx_cycles = wire_time(mode_next, baud_next);
            end
        end
    end

    // output register plus skid
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg) begin
            if (accept) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                if (accept) begin
                    out_next = res;
                end
            end
        end else if (accept) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg       <= 1'b0;
            mode_reg       <= '0;
            ctrl_reg       <= '0;
            baud_reg       <= '0;
            hold_byte_reg  <= '0;
            hold_full_reg  <= 1'b0;
            sending_reg    <= 1'b0;
            remain_reg     <= '0;
            err_reg        <= '0;
            irq_reg        <= 1'b0;
            dsr_reg        <= 1'b0;
            cts_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                link_reg <= cfg_link_enabled;
            end
            mode_reg       <= mode_next;
            ctrl_reg       <= ctrl_next;
            baud_reg       <= baud_next;
            hold_byte_reg  <= hold_byte_next;
            hold_full_reg  <= hold_full_next;
            sending_reg    <= sending_next;
            remain_reg     <= remain_next;
            err_reg        <= err_next;
            irq_reg        <= irq_next;
            dsr_reg        <= dsr_next;
            cts_reg        <= cts_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_rdata       = out_reg.rdata;
    assign m_tx_valid    = out_reg.tx_valid;
    assign m_tx_byte     = out_reg.tx_byte;
    assign m_tx_cycles   = out_reg.tx_cycles;
    assign m_lines_valid = out_reg.lines_valid;
    assign m_dtr_out     = out_reg.dtr_out;
    assign m_rts_out     = out_reg.rts_out;
    assign m_irq_raise   = out_reg.irq_raise;

endmodule

/* verif/tb_serial_port_with_rx_fifo.sv */
module tb_serial_port_with_rx_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = sprx_pkg::FIFO_DEPTH;

    // bus commands carried by s_cmd
    typedef enum bit [3:0] {
        CMD_WR_DATA, CMD_WR_MODE, CMD_WR_CTRL, CMD_WR_BAUD,
        CMD_RD_DATA, CMD_RD_STAT, CMD_RD_MODE, CMD_RD_CTRL, CMD_RD_BAUD,
        CMD_RX_BYTE, CMD_PEER_LINES, CMD_TICK,
        CMD_RSVD_C, CMD_RSVD_D, CMD_RSVD_E, CMD_RSVD_F
    } cmd_e;

    // control word bits
    localparam bit [15:0] CT_TX_EN   = 16'h0001;
    localparam bit [15:0] CT_DTR     = 16'h0002;
    localparam bit [15:0] CT_ACK     = 16'h0010;
    localparam bit [15:0] CT_RTS     = 16'h0020;
    localparam bit [15:0] CT_RESET   = 16'h0040;
    localparam bit [15:0] CT_TX_IRQ  = 16'h0400;
    localparam bit [15:0] CT_RX_IRQ  = 16'h0800;
    localparam bit [15:0] CT_DSR_IRQ = 16'h1000;

    // status word bits
    localparam bit [15:0] ST_TX_RDY   = 16'h0001;
    localparam bit [15:0] ST_RX_RDY   = 16'h0002;
    localparam bit [15:0] ST_TX_EMPTY = 16'h0004;
    localparam bit [15:0] ST_DSR      = 16'h0080;
    localparam bit [15:0] ST_CTS      = 16'h0100;
    localparam bit [15:0] ST_IRQ      = 16'h0200;

    localparam bit [2:0]  ERR_OVERRUN  = 3'b010;
    localparam bit [15:0] STAT_NO_LINK = 16'h00a0;
    localparam bit [15:0] RD_EMPTY     = 16'h00ff;
    localparam int unsigned MIN_BIT_TIME = 8;
    localparam int unsigned CLK_FACTOR [4] = '{1, 1, 16, 64};

    // one result word, field by field
    typedef struct packed {
        logic [15:0] rdata;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [25:0] tx_cycles;
        logic        lines_valid;
        logic        dtr_out;
        logic        rts_out;
        logic        irq_raise;
    } port_result_t;

    // shadow of the port state plus the results still owed by the block
    class port_result_board;
        port_result_t due[$];
        int unsigned  errors;

        bit           link;
        bit [15:0]    mode_w, ctrl_w, baud_w;
        bit [7:0]     rx_q [FIFO_DEPTH];
        int unsigned  head, fill;
        bit [7:0]     hold;
        bit           hold_full, sending;
        bit [25:0]    remaining;
        bit [2:0]     err;
        bit           irq_pend, dsr_lvl, cts_lvl;
        port_result_t cur;

        function new();
            link   = 1'b0;
            errors = 0;
            clear_port();
        endfunction

        function void clear_port();
            mode_w = '0; ctrl_w = '0; baud_w = '0;
            head = 0; fill = 0;
            hold = '0; hold_full = 1'b0; sending = 1'b0; remaining = '0;
            err = '0; irq_pend = 1'b0; dsr_lvl = 1'b0; cts_lvl = 1'b0;
        endfunction

        function void set_link(bit v);
            link = v;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function void raise_irq();
            if (!irq_pend) begin
                irq_pend      = 1'b1;
                cur.irq_raise = 1'b1;
            end
        endfunction

        // put the held byte on the wire if the transmitter is free and enabled; with no link it is dropped
        function void start_send();
            int unsigned bit_time, nbits;
            if (sending || !hold_full || (ctrl_w & CT_TX_EN) == 0)
                return;
            hold_full = 1'b0;
            if (!link)
                return;
            bit_time = baud_w * CLK_FACTOR[mode_w[1:0]];
            if (bit_time < MIN_BIT_TIME)
                bit_time = MIN_BIT_TIME;
            nbits = 6 + mode_w[3:2] + mode_w[4] + ((mode_w[7:6] == 2'b11) ? 2 : 1);
            sending       = 1'b1;
            remaining     = 26'(bit_time * nbits);
            cur.tx_valid  = 1'b1;
            cur.tx_byte   = hold;
            cur.tx_cycles = remaining;
        endfunction

        function void predict_access(cmd_e c, bit [15:0] wd, bit [7:0] pb,
                                     bit dsr_in, bit cts_in);
            bit [15:0] was;
            bit        rising;
            cur = '0;
            case (c)
                CMD_WR_DATA: begin
                    hold      = wd[7:0];
                    hold_full = 1'b1;
                    start_send();
                end
                CMD_WR_MODE: mode_w = wd;
                CMD_WR_CTRL: begin
                    was = ctrl_w;
                    if ((wd & CT_RESET) != 0) begin
                        // momentary reset, lines go back to low
                        clear_port();
                        if (link)
                            cur.lines_valid = 1'b1;
                    end else begin
                        if ((wd & CT_ACK) != 0) begin
                            err      = '0;
                            irq_pend = 1'b0;
                        end
                        ctrl_w = wd & ~(CT_ACK | CT_RESET);
                        if (((ctrl_w ^ was) & (CT_DTR | CT_RTS)) != 0 && link) begin
                            cur.lines_valid = 1'b1;
                            cur.dtr_out     = (ctrl_w & CT_DTR) != 0;
                            cur.rts_out     = (ctrl_w & CT_RTS) != 0;
                        end
                        start_send();
                    end
                end
                CMD_WR_BAUD: baud_w = wd;
                CMD_RD_DATA: begin
                    if (fill == 0) begin
                        cur.rdata = RD_EMPTY;
                    end else begin
                        cur.rdata = {8'h00, rx_q[head]};
                        head      = (head + 1) % FIFO_DEPTH;
                        fill--;
                    end
                end
                CMD_RD_STAT: begin
                    if (!link) begin
                        cur.rdata = STAT_NO_LINK;
                    end else begin
                        cur.rdata = {10'h0, err, 3'b000};
                        if (!hold_full)             cur.rdata |= ST_TX_RDY;
                        if (!hold_full && !sending) cur.rdata |= ST_TX_EMPTY;
                        if (fill != 0)              cur.rdata |= ST_RX_RDY;
                        if (dsr_lvl)                cur.rdata |= ST_DSR;
                        if (cts_lvl)                cur.rdata |= ST_CTS;
                        if (irq_pend)               cur.rdata |= ST_IRQ;
                    end
                end
                CMD_RD_MODE: cur.rdata = mode_w;
                CMD_RD_CTRL: cur.rdata = ctrl_w;
                CMD_RD_BAUD: cur.rdata = baud_w;
                CMD_RX_BYTE: begin
                    if (link) begin
                        if (fill >= FIFO_DEPTH) begin
                            err |= ERR_OVERRUN;
                        end else begin
                            rx_q[(head + fill) % FIFO_DEPTH] = pb;
                            fill++;
                            if ((ctrl_w & CT_RX_IRQ) != 0 && fill >= (1 << ctrl_w[9:8]))
                                raise_irq();
                        end
                    end
                end
                CMD_PEER_LINES: begin
                    if (link) begin
                        rising  = dsr_in && !dsr_lvl;
                        dsr_lvl = dsr_in;
                        cts_lvl = cts_in;
                        if (rising && (ctrl_w & CT_DSR_IRQ) != 0)
                            raise_irq();
                    end
                end
                CMD_TICK: begin
                    if (link && sending) begin
                        if (remaining != 0)
                            remaining--;
                        if (remaining == 0) begin
                            sending = 1'b0;
                            if ((ctrl_w & CT_TX_IRQ) != 0)
                                raise_irq();
                            start_send();
                        end
                    end
                end
                default: ;
            endcase
            due.push_back(cur);
        endfunction

        function void compare_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", fname, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(port_result_t got);
            port_result_t want;
            if (due.size() == 0) begin
                $error("result word with no access waiting, rdata 0x%0h", got.rdata);
                errors++;
                return;
            end
            want = due.pop_front();
            compare_field("rdata", want.rdata, got.rdata);
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("tx_cycles", want.tx_cycles, got.tx_cycles);
            compare_field("lines_valid", want.lines_valid, got.lines_valid);
            compare_field("dtr_out", want.dtr_out, got.dtr_out);
            compare_field("rts_out", want.rts_out, got.rts_out);
            compare_field("irq_raise", want.irq_raise, got.irq_raise);
        endfunction
    endclass

    // clock, reset and block ports
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic        cfg_link_enabled = 1'b0;

    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [3:0]  s_cmd       = '0;
    logic [15:0] s_wdata     = '0;
    logic [7:0]  s_peer_byte = '0;
    logic        s_peer_dsr  = 1'b0;
    logic        s_peer_cts  = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_rdata;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic [25:0] m_tx_cycles;
    logic        m_lines_valid;
    logic        m_dtr_out;
    logic        m_rts_out;
    logic        m_irq_raise;

    port_result_board sb;
    bit               idle_on    = 1'b1;
    int unsigned      words_sent = 0;

    serial_port_with_rx_fifo dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_link_enabled (cfg_link_enabled),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_wdata          (s_wdata),
        .s_peer_byte      (s_peer_byte),
        .s_peer_dsr       (s_peer_dsr),
        .s_peer_cts       (s_peer_cts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rdata          (m_rdata),
        .m_tx_valid       (m_tx_valid),
        .m_tx_byte        (m_tx_byte),
        .m_tx_cycles      (m_tx_cycles),
        .m_lines_valid    (m_lines_valid),
        .m_dtr_out        (m_dtr_out),
        .m_rts_out        (m_rts_out),
        .m_irq_raise      (m_irq_raise)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side backpressure, about 14 stalls in a hundred while idling is on
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 14);
    end

    // watch all three handshakes; results are checked before the new word is
    // noted, since a word can never produce its result on its own edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(port_result_t'{m_rdata, m_tx_valid, m_tx_byte, m_tx_cycles,
                                               m_lines_valid, m_dtr_out, m_rts_out,
                                               m_irq_raise});
            if (cfg_valid && cfg_ready)
                sb.set_link(cfg_link_enabled);
            if (s_valid && s_ready)
                sb.predict_access(cmd_e'(s_cmd), s_wdata, s_peer_byte, s_peer_dsr, s_peer_cts);
        end
    end

    // present one word and hold it until taken, with random gaps in front
    task send_word(input cmd_e c, input bit [15:0] wd, input bit [7:0] pb,
                   input bit dsr_in, input bit cts_in);
        while (idle_on && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= c;
        s_wdata     <= wd;
        s_peer_byte <= pb;
        s_peer_dsr  <= dsr_in;
        s_peer_cts  <= cts_in;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
    endtask

    // same, with random peer fields
    task send_cmd(input cmd_e c, input bit [15:0] wd);
        send_word(c, wd, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // stop sending and wait for every owed result, then let the pipe settle
    task drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // link partner register write, only while the port is quiet
    task set_link_partner(input bit v);
        cfg_valid        <= 1'b1;
        cfg_link_enabled <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mixes of short access sequences until the word count reaches upto
    task run_random(input int unsigned upto);
        int unsigned pick;
        bit [15:0]   mode_v;
        bit [15:0]   wd;
        cmd_e        c;
        while (words_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // transmit: small wire time, bytes queued while ticks run down
                if ($urandom_range(1))
                    send_cmd(CMD_WR_CTRL, 16'($urandom) | CT_RESET);
                mode_v = 16'($urandom);
                send_cmd(CMD_WR_MODE, mode_v);
                // slow clock factors only with a zero divisor
                send_cmd(CMD_WR_BAUD, mode_v[1] ? 16'd0 : 16'($urandom_range(2)));
                send_cmd(CMD_WR_CTRL, (16'($urandom) & ~CT_RESET) | CT_TX_EN);
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(CMD_WR_DATA, 16'($urandom));
                    repeat ($urandom_range(20, 110)) begin
                        if ($urandom_range(9) == 0)
                            send_cmd(CMD_RD_STAT, 16'($urandom));
                        else
                            send_cmd(CMD_TICK, 16'($urandom));
                    end
                end
            end else if (pick < 55) begin
                // receive: fill, maybe overrun, drain, acknowledge
                send_cmd(CMD_WR_CTRL, (16'($urandom) & ~CT_RESET) | CT_RX_IRQ);
                repeat ($urandom_range(1, FIFO_DEPTH + 2))
                    send_cmd(CMD_RX_BYTE, 16'($urandom));
                send_cmd(CMD_RD_STAT, 16'($urandom));
                repeat ($urandom_range(1, FIFO_DEPTH + 2))
                    send_cmd(CMD_RD_DATA, 16'($urandom));
                send_cmd(CMD_WR_CTRL, (16'($urandom) & ~CT_RESET) | CT_ACK);
            end else if (pick < 65) begin
                // peer line changes with the dsr interrupt armed
                send_cmd(CMD_WR_CTRL, (16'($urandom) & ~CT_RESET) | CT_DSR_IRQ);
                repeat ($urandom_range(2, 6))
                    send_cmd(CMD_PEER_LINES, 16'($urandom));
                send_cmd(CMD_RD_STAT, 16'($urandom));
            end else if (pick < 85) begin
                // register writes and reads with full-range values
                repeat ($urandom_range(2, 6)) begin
                    c  = cmd_e'($urandom_range(CMD_WR_DATA, CMD_RD_BAUD));
                    wd = 16'($urandom);
                    if (c == CMD_WR_CTRL && $urandom_range(7) != 0)
                        wd &= ~CT_RESET;
                    send_cmd(c, wd);
                end
            end else begin
                // anything, unused commands included
                repeat ($urandom_range(1, 4))
                    send_cmd(cmd_e'($urandom_range(15)), 16'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned k;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_link_partner(1'b1);

        // directed: reset values, extremes, fifo overrun, threshold, ack, dsr, reset
        send_cmd(CMD_RD_STAT, 16'hffff);
        send_cmd(CMD_RD_DATA, 16'h0000);
        send_cmd(CMD_WR_MODE, 16'hffff);
        send_cmd(CMD_WR_BAUD, 16'hffff);
        // every control bit but reset: tx on, lines up, all irqs, threshold at 8
        send_cmd(CMD_WR_CTRL, ~CT_RESET);
        // longest wire time
        send_word(CMD_WR_DATA, 16'hff5a, 8'hff, 1'b1, 1'b1);
        send_cmd(CMD_TICK, 16'h0000);
        // fill the fifo to the threshold, then one more for the overrun
        for (k = 0; k <= FIFO_DEPTH; k++)
            send_word(CMD_RX_BYTE, 16'h0000, k[0] ? 8'hff : 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_RD_STAT, 16'h0000);
        send_cmd(CMD_WR_CTRL, ~CT_RESET);
        send_word(CMD_PEER_LINES, 16'h0000, 8'h00, 1'b1, 1'b1);
        send_word(CMD_PEER_LINES, 16'hffff, 8'hff, 1'b0, 1'b0);
        send_cmd(CMD_RD_DATA, 16'h0000);
        send_cmd(CMD_WR_CTRL, CT_RESET);
        send_cmd(CMD_RD_CTRL, 16'h0000);
        send_cmd(CMD_RSVD_F, 16'hffff);
        send_cmd(CMD_RSVD_C, 16'h0000);
        drain_results();

        // linked, idling on both sides
        run_random(words_sent + 450);
        // sender holds off until every result is back
        drain_results();
        run_random(words_sent + 250);

        // leave a byte on the wire, then drop the partner mid-send
        send_cmd(CMD_WR_CTRL, CT_RESET);
        send_cmd(CMD_WR_CTRL, CT_TX_EN);
        send_cmd(CMD_WR_DATA, 16'($urandom));
        drain_results();
        set_link_partner(1'b0);
        run_random(words_sent + 150);
        drain_results();
        set_link_partner(1'b1);

        // long stretch at full rate, no gaps on either side
        idle_on <= 1'b0;
        run_random(words_sent + 200);
        idle_on <= 1'b1;
        run_random(words_sent + 200);
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_serial_port_with_rx_fifo: PASS");
        else
            $display("tb_serial_port_with_rx_fifo: FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("tb_serial_port_with_rx_fifo: FAIL");
        $finish;
    end

endmodule

/* serial_port_with_rx_fifo.f */
rtl/sprx_pkg.sv
rtl/sprx_rx_fifo.sv
rtl/serial_port_with_rx_fifo.sv
verif/tb_serial_port_with_rx_fifo.sv
